// ===== sv/nfa_state_set_matcher_core_assert.svh =====
// assertion macros used by the matcher's port-level checker
`ifndef NFA_STATE_SET_MATCHER_CORE_ASSERT_SVH
`define NFA_STATE_SET_MATCHER_CORE_ASSERT_SVH

// same-cycle implication, clocked on aclk, off while in reset
`define NFAM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off while in reset
`define NFAM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/nfam_pkg.sv =====
// shared types and constants of the nfa state set matcher
package nfam_pkg;

    localparam int unsigned CMD_W          = 3;
    localparam int unsigned STATE_FIELD_W  = 5;
    localparam int unsigned SYMBOL_FIELD_W = 8;
    localparam int unsigned CFG_INDEX_W    = 1;
    localparam int unsigned CFG_DATA_W     = 32;
    localparam int unsigned ACCEPT_W       = 32;

    // item commands
    localparam logic [CMD_W-1:0] CMD_ADD_SYM    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE_SYM = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ADD_EPS    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE_EPS = 3'd3;
    localparam logic [CMD_W-1:0] CMD_START      = 3'd4;
    localparam logic [CMD_W-1:0] CMD_STEP       = 3'd5;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_START_STATE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACCEPT_MASK = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic [STATE_FIELD_W-1:0]  from_state;
        logic [STATE_FIELD_W-1:0]  to_state;
        logic [SYMBOL_FIELD_W-1:0] symbol;
    } in_item_t;

    typedef struct packed {
        logic matched;
        logic alive;
        logic status;
    } out_item_t;

endpackage

// ===== sv/nfam_ram.sv =====
// generic simple dual-port ram with registered read
module nfam_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/nfa_state_set_matcher_core.sv =====
// top level of the bit-vector nfa state set matcher
//
//  channel | ports                               | carries
//  --------+-------------------------------------+---------------------------------
//  input   | s_valid s_ready s_data              | command, from/to state, symbol
//  result  | m_valid m_ready m_data              | matched, alive, status
//  config  | cfg_valid cfg_ready cfg_index/data  | start_state, accept_mask
//
// one item at a time; the result register is loaded from ST_DONE after: edge commands
// pass ST_EDGE_RD and ST_EDGE_MOD, start runs the ST_CLOSE_RD/ST_CLOSE_OR closure loop,
// step runs ST_GATHER (one read per active state) and then the closure loop; the
// one-read-per-cycle successor memories set the pace.
// after reset a clearing pass over all 2^(clog2(NUM_STATES)+SYMBOL_BITS) entries (8192 by
// default) zeroes the symbol table; s_ready stays low, config writes are taken.
// a stalled result sits in the output register while the next item is accepted.
module nfa_state_set_matcher_core #(
    parameter int unsigned NUM_STATES  = 32,
    parameter int unsigned SYMBOL_BITS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  nfam_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output nfam_pkg::out_item_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [nfam_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [nfam_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int unsigned SW = $clog2(NUM_STATES);
    localparam int unsigned AW = SW + SYMBOL_BITS;
    localparam int unsigned SYM_DEPTH = 1 << AW;

    typedef enum logic [7:0] {
        ST_CLEAR    = 8'b0000_0001,
        ST_IDLE     = 8'b0000_0010,
        ST_EDGE_RD  = 8'b0000_0100,
        ST_EDGE_MOD = 8'b0000_1000,
        ST_GATHER   = 8'b0001_0000,
        ST_CLOSE_RD = 8'b0010_0000,
        ST_CLOSE_OR = 8'b0100_0000,
        ST_DONE     = 8'b1000_0000
    } state_t;

    state_t                 state_reg, state_next;
    nfam_pkg::in_item_t     item_reg, item_next;
    logic [NUM_STATES-1:0]  active_reg, active_next;
    logic [NUM_STATES-1:0]  work_reg, work_next;
    logic [NUM_STATES-1:0]  pend_reg, pend_next;
    logic                   rd_pend_reg, rd_pend_next;
    logic                   status_reg, status_next;
    logic [AW-1:0]          clr_addr_reg, clr_addr_next;
    logic [NUM_STATES-1:0]  eps_valid_reg, eps_valid_next;
    logic                   eps_rd_ok_reg;
    logic [nfam_pkg::STATE_FIELD_W-1:0] start_state_reg;
    logic [nfam_pkg::ACCEPT_W-1:0]      accept_mask_reg;
    logic                   m_valid_reg, m_valid_next;
    nfam_pkg::out_item_t    m_data_reg, m_data_next;

    logic [SW-1:0]          from_idx;
    logic [SYMBOL_BITS-1:0] sym_idx;
    logic                   from_ok, to_ok, sym_ok, s_sym_ok, start_ok, edge_ok;
    logic                   is_sym_cmd, is_add, present, write_en;
    logic [NUM_STATES-1:0]  to_bit, start_bit, edge_word, new_word, fresh;
    logic [NUM_STATES-1:0]  low_onehot;
    logic [SW-1:0]          low_idx;

    logic                   sym_we;
    logic [AW-1:0]          sym_waddr, sym_raddr;
    logic [NUM_STATES-1:0]  sym_wdata, sym_rdata;
    logic                   eps_we;
    logic [SW-1:0]          eps_raddr;
    logic [NUM_STATES-1:0]  eps_raw, eps_rdata;

    // successor tables
    nfam_ram #(.WIDTH(NUM_STATES), .DEPTH(SYM_DEPTH)) u_sym_ram (
        .aclk  (aclk),
        .we    (sym_we),
        .waddr (sym_waddr),
        .wdata (sym_wdata),
        .raddr (sym_raddr),
        .rdata (sym_rdata)
    );

    nfam_ram #(.WIDTH(NUM_STATES), .DEPTH(NUM_STATES)) u_eps_ram (
        .aclk  (aclk),
        .we    (eps_we),
        .waddr (from_idx),
        .wdata (new_word),
        .raddr (eps_raddr),
        .rdata (eps_raw)
    );

    // fields of the item in work and their range checks
    assign from_idx  = SW'(item_reg.from_state);
    assign sym_idx   = SYMBOL_BITS'(item_reg.symbol);
    assign from_ok   = 32'(item_reg.from_state) < NUM_STATES;
    assign to_ok     = 32'(item_reg.to_state) < NUM_STATES;
    assign sym_ok    = (32'(item_reg.symbol) >> SYMBOL_BITS) == 32'd0;
    assign s_sym_ok  = (32'(s_data.symbol) >> SYMBOL_BITS) == 32'd0;
    assign start_ok  = 32'(start_state_reg) < NUM_STATES;
    assign to_bit    = to_ok ? (NUM_STATES'(1) << item_reg.to_state) : '0;
    assign start_bit = start_ok ? (NUM_STATES'(1) << start_state_reg) : '0;

    assign is_sym_cmd = (item_reg.command == nfam_pkg::CMD_ADD_SYM) ||
                        (item_reg.command == nfam_pkg::CMD_REMOVE_SYM);
    assign is_add     = (item_reg.command == nfam_pkg::CMD_ADD_SYM) ||
                        (item_reg.command == nfam_pkg::CMD_ADD_EPS);
    assign edge_ok    = from_ok && to_ok && (sym_ok || !is_sym_cmd);

    // unwritten epsilon rows read as empty
    assign eps_rdata = eps_rd_ok_reg ? eps_raw : '0;

    // read-modify-write of one successor word
    assign edge_word = is_sym_cmd ? sym_rdata : eps_rdata;
    assign present   = |(edge_word & to_bit);
    assign new_word  = is_add ? (edge_word | to_bit) : (edge_word & ~to_bit);
    assign write_en  = (state_reg == ST_EDGE_MOD) && edge_ok && (is_add || present);

    // lowest pending state
    assign low_onehot = pend_reg & (~pend_reg + NUM_STATES'(1));
    always_comb begin
        low_idx = '0;
        for (int i = 0; i < NUM_STATES; i++) begin
            low_idx = low_idx | (low_onehot[i] ? SW'(i) : '0);
        end
    end

    // memory ports
    assign sym_we    = (state_reg == ST_CLEAR) || (write_en && is_sym_cmd);
    assign sym_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : {from_idx, sym_idx};
    assign sym_wdata = (state_reg == ST_CLEAR) ? '0 : new_word;
    assign sym_raddr = (state_reg == ST_GATHER) ? {low_idx, sym_idx} : {from_idx, sym_idx};
    assign eps_we    = write_en && !is_sym_cmd;
    assign eps_raddr = (state_reg == ST_CLOSE_RD) ? low_idx : from_idx;
    assign fresh     = eps_rdata & ~work_reg;

    // epsilon row valid bits
    always_comb begin
        eps_valid_next = eps_valid_reg;
        if (eps_we) begin
            eps_valid_next[from_idx] = 1'b1;
        end
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        active_next   = active_reg;
        work_next     = work_reg;
        pend_next     = pend_reg;
        rd_pend_next  = rd_pend_reg;
        status_next   = status_reg;
        clr_addr_next = clr_addr_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        case (state_reg)
            ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    item_next   = s_data;
                    status_next = 1'b0;
                    case (s_data.command)
                        nfam_pkg::CMD_ADD_SYM, nfam_pkg::CMD_REMOVE_SYM,
                        nfam_pkg::CMD_ADD_EPS, nfam_pkg::CMD_REMOVE_EPS: begin
                            state_next = ST_EDGE_RD;
                        end
                        nfam_pkg::CMD_START: begin
                            work_next  = start_bit;
                            pend_next  = start_bit;
                            state_next = ST_CLOSE_RD;
                        end
                        nfam_pkg::CMD_STEP: begin
                            work_next    = '0;
                            pend_next    = s_sym_ok ? active_reg : '0;
                            rd_pend_next = 1'b0;
                            state_next   = ST_GATHER;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_EDGE_RD: begin
                state_next = ST_EDGE_MOD;
            end
            ST_EDGE_MOD: begin
                status_next = !is_add && !(edge_ok && present);
                state_next  = ST_DONE;
            end
            ST_GATHER: begin
                // one symbol successor read per cycle, ORed into the work set in the next cycle
                work_next = work_reg | (rd_pend_reg ? sym_rdata : '0);
                if (pend_reg != '0) begin
                    pend_next    = pend_reg & ~low_onehot;
                    rd_pend_next = 1'b1;
                end else begin
                    rd_pend_next = 1'b0;
                    if (!rd_pend_reg) begin
                        pend_next  = work_reg;
                        state_next = ST_CLOSE_RD;
                    end
                end
            end
            ST_CLOSE_RD: begin
                // worklist closure: each reached state is expanded once
                if (pend_reg == '0) begin
                    active_next = work_reg;
                    state_next  = ST_DONE;
                end else begin
                    pend_next  = pend_reg & ~low_onehot;
                    state_next = ST_CLOSE_OR;
                end
            end
            ST_CLOSE_OR: begin
                work_next  = work_reg | fresh;
                pend_next  = pend_reg | fresh;
                state_next = ST_CLOSE_RD;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next        = 1'b1;
                    m_data_next.matched = |(active_reg & NUM_STATES'(accept_mask_reg));
                    m_data_next.alive   = |active_reg;
                    m_data_next.status  = status_reg;
                    state_next          = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_addr_reg    <= '0;
            eps_valid_reg   <= '0;
            active_reg      <= '0;
            rd_pend_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
            start_state_reg <= '0;
            accept_mask_reg <= '0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            eps_valid_reg <= eps_valid_next;
            active_reg    <= active_next;
            rd_pend_reg   <= rd_pend_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_valid) begin
                case (cfg_index)
                    nfam_pkg::CFG_START_STATE: begin
                        start_state_reg <= cfg_data[nfam_pkg::STATE_FIELD_W-1:0];
                    end
                    nfam_pkg::CFG_ACCEPT_MASK: begin
                        accept_mask_reg <= cfg_data[nfam_pkg::ACCEPT_W-1:0];
                    end
                    default: begin
                        accept_mask_reg <= accept_mask_reg;
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        item_reg      <= item_next;
        work_reg      <= work_next;
        pend_reg      <= pend_next;
        status_reg    <= status_next;
        m_data_reg    <= m_data_next;
        eps_rd_ok_reg <= eps_valid_reg[eps_raddr];
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

endmodule

// ===== sv/nfam_checker.sv =====
// port-level checker of the matcher and its bind
`include "nfa_state_set_matcher_core_assert.svh"

module nfam_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input nfam_pkg::out_item_t m_data
);

    // a stalled result holds
    `NFAM_ASSERT_NEXT(a_result_holds, m_valid && !m_ready, m_valid && $stable(m_data), "result changed under stall")

    // one item in work at a time
    `NFAM_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "second item taken while busy")

    // a new result appears as the block returns to idle
    `NFAM_ASSERT_SAME(a_idle_with_result, $rose(m_valid), s_ready, "result raised while not idle")

    // a match needs a live state set
    `NFAM_ASSERT_SAME(a_match_needs_alive, m_valid, !(m_data.matched && !m_data.alive), "matched with empty set")

endmodule

bind nfa_state_set_matcher_core nfam_checker u_nfam_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== sim/nfa_match_checker.sv =====
// checker for the nfa state set matcher: predicts every result and compares it
module nfa_match_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  nfam_pkg::in_item_t                s_data,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  nfam_pkg::out_item_t               m_data,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [nfam_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [nfam_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                                pending,
    output int                                failures
);
    timeunit 1ns;
    timeprecision 1ps;

    import nfam_pkg::*;

    localparam int STATES  = 32;
    localparam int SYMBOLS = 256;

    // own copy of the transition tables, the live set and the registers
    logic [31:0]  symbol_next [0:STATES*SYMBOLS-1];
    logic [31:0]  epsilon_next [0:STATES-1];
    logic [31:0]  live_states;
    logic [4:0]   start_reg;
    logic [31:0]  accept_reg;

    out_item_t    awaited_flags [$];
    int           mismatch_total = 0;
    int           result_index = 0;

    // grow a set over epsilon edges until it stops changing
    function automatic logic [31:0] epsilon_closure(input logic [31:0] seed);
        logic [31:0] grown;
        logic        settled;
        int          pass;
        int          s;
        settled = 1'b0;
        for (pass = 0; pass < STATES && !settled; pass++) begin
            grown = seed;
            for (s = 0; s < STATES; s++) begin
                if (seed[s]) begin
                    grown |= epsilon_next[s];
                end
            end
            if (grown == seed) begin
                settled = 1'b1;
            end
            seed = grown;
        end
        return seed;
    endfunction

    // apply one command to the tables and the live set, give back its flags
    task automatic apply_command(input in_item_t cmd, output out_item_t flags);
        int          slot;
        int          s;
        logic [31:0] dest;
        logic [31:0] gathered;
        slot  = int'(cmd.from_state) * SYMBOLS + int'(cmd.symbol);
        dest  = 32'd1 << cmd.to_state;
        flags = '0;
        case (cmd.command)
            CMD_ADD_SYM: begin
                symbol_next[slot] |= dest;
            end
            CMD_REMOVE_SYM: begin
                if ((symbol_next[slot] & dest) != 32'd0) begin
                    symbol_next[slot] &= ~dest;
                end else begin
                    flags.status = 1'b1;
                end
            end
            CMD_ADD_EPS: begin
                epsilon_next[cmd.from_state] |= dest;
            end
            CMD_REMOVE_EPS: begin
                if ((epsilon_next[cmd.from_state] & dest) != 32'd0) begin
                    epsilon_next[cmd.from_state] &= ~dest;
                end else begin
                    flags.status = 1'b1;
                end
            end
            CMD_START: begin
                live_states = epsilon_closure(32'd1 << start_reg);
            end
            CMD_STEP: begin
                gathered = '0;
                for (s = 0; s < STATES; s++) begin
                    if (live_states[s]) begin
                        gathered |= symbol_next[s * SYMBOLS + int'(cmd.symbol)];
                    end
                end
                live_states = epsilon_closure(gathered);
            end
            default: begin
            end
        endcase
        flags.matched = |(live_states & accept_reg);
        flags.alive   = |live_states;
    endtask

    task automatic flag_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_total++;
    endtask

    // watch all three channels; results are compared before new items are predicted
    always @(posedge aclk) begin : watch_channels
        out_item_t want;
        out_item_t fresh;
        int        i;
        if (!aresetn) begin
            for (i = 0; i < STATES * SYMBOLS; i++) begin
                symbol_next[i] = '0;
            end
            for (i = 0; i < STATES; i++) begin
                epsilon_next[i] = '0;
            end
            live_states = '0;
            start_reg   = '0;
            accept_reg  = '0;
            awaited_flags.delete();
        end else begin
            // result side
            if (m_valid && m_ready) begin
                if (awaited_flags.size() == 0) begin
                    flag_mismatch($sformatf("result %0d came with no item awaiting it",
                                            result_index));
                end else begin
                    want = awaited_flags.pop_front();
                    if (m_data.matched !== want.matched) begin
                        flag_mismatch($sformatf("result %0d matched %b, want %b",
                                                result_index, m_data.matched, want.matched));
                    end
                    if (m_data.alive !== want.alive) begin
                        flag_mismatch($sformatf("result %0d alive %b, want %b",
                                                result_index, m_data.alive, want.alive));
                    end
                    if (m_data.status !== want.status) begin
                        flag_mismatch($sformatf("result %0d status %b, want %b",
                                                result_index, m_data.status, want.status));
                    end
                end
                result_index++;
            end
            // register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_START_STATE: start_reg  = cfg_data[4:0];
                    CFG_ACCEPT_MASK: accept_reg = cfg_data;
                    default: begin
                    end
                endcase
            end
            // input side
            if (s_valid && s_ready) begin
                apply_command(s_data, fresh);
                awaited_flags.push_back(fresh);
            end
        end
        pending  <= awaited_flags.size();
        failures <= mismatch_total;
    end

endmodule

// ===== sim/tb_nfa_state_set_matcher_core.sv =====
// testbench top of the nfa state set matcher: stimulus, pacing and verdict
module tb_nfa_state_set_matcher_core;
    timeunit 1ns;
    timeprecision 1ps;

    import nfam_pkg::*;

    // command codes the block leaves unused
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    localparam int ITEM_TARGET = 1625;
    localparam int CALM_FROM   = 1450;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    in_item_t                s_data;
    logic                    m_valid;
    logic                    m_ready;
    out_item_t               m_data;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    int  pending;
    int  failures;
    bit  calm = 1'b0;

    int  sent = 0;
    int  step_count = 0;
    int  start_count = 0;
    int  reg_writes = 0;
    int  phases = 0;

    logic [4:0] state_pool [0:5];
    logic [7:0] symbol_pool [0:2];

    nfa_state_set_matcher_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    nfa_match_checker match_watch (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pending   (pending),
        .failures  (failures)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // hard stop well past the slowest correct run
    initial begin : watchdog
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    // result side back-pressure in random bursts, none in the closing stretch
    initial begin : result_pacing
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            if (calm) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else if ($urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end
        end
    end

    function automatic in_item_t make_item(input logic [CMD_W-1:0] c, input logic [4:0] f,
                                           input logic [4:0] t, input logic [7:0] y);
        in_item_t it;
        it.command    = c;
        it.from_state = f;
        it.to_state   = t;
        it.symbol     = y;
        return it;
    endfunction

    function automatic logic [4:0] pick_state();
        return state_pool[$urandom_range(0, 5)];
    endfunction

    function automatic logic [7:0] pick_symbol();
        return symbol_pool[$urandom_range(0, 2)];
    endfunction

    // offer one item, optionally after a random gap, and hold it until taken
    task automatic send_command(input in_item_t it);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        sent++;
        if (it.command == CMD_STEP) begin
            step_count++;
        end
        if (it.command == CMD_START) begin
            start_count++;
        end
        if (sent >= CALM_FROM) begin
            calm <= 1'b1;
        end
    endtask

    // stop sending and wait until every awaited result has been taken
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // cfg_valid is left high; the caller lowers it after the last write
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        reg_writes++;
    endtask

    initial begin : stimulus
        in_item_t    item;
        in_item_t    undo_eps [$];
        in_item_t    added_sym [$];
        logic [20:0] raw;
        logic [4:0]  st;
        logic [31:0] mask;
        int          k;
        int          r;
        int          budget;
        bit          chain;

        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        aresetn   = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part: empty set, absent removes, duplicates, spare codes
        write_register(CFG_START_STATE, 32'd0);
        write_register(CFG_ACCEPT_MASK, 32'h0000_0000);
        cfg_valid <= 1'b0;
        send_command(make_item(CMD_STEP, 5'd0, 5'd0, 8'd0));
        send_command(make_item(CMD_REMOVE_SYM, 5'd0, 5'd0, 8'd0));
        send_command(make_item(CMD_REMOVE_EPS, 5'd31, 5'd31, 8'd255));
        send_command(make_item(CMD_ADD_SYM, 5'd0, 5'd31, 8'd255));
        send_command(make_item(CMD_ADD_SYM, 5'd0, 5'd31, 8'd255));
        send_command(make_item(CMD_ADD_SYM, 5'd31, 5'd0, 8'd0));
        send_command(make_item(CMD_ADD_EPS, 5'd0, 5'd31, 8'd0));
        send_command(make_item(CMD_ADD_EPS, 5'd0, 5'd31, 8'd0));
        send_command(make_item(CMD_START, 5'd0, 5'd0, 8'd0));
        send_command(make_item(CMD_STEP, 5'd0, 5'd0, 8'd255));
        send_command(make_item(CMD_STEP, 5'd31, 5'd31, 8'd0));
        send_command(make_item(CMD_SPARE_6, 5'd31, 5'd31, 8'd255));
        send_command(make_item(CMD_SPARE_7, 5'd0, 5'd0, 8'd0));
        send_command(make_item(CMD_REMOVE_SYM, 5'd0, 5'd31, 8'd255));
        send_command(make_item(CMD_REMOVE_SYM, 5'd0, 5'd31, 8'd255));
        send_command(make_item(CMD_REMOVE_EPS, 5'd0, 5'd31, 8'd0));
        send_command(make_item(CMD_STEP, 5'd0, 5'd0, 8'd0));
        send_command(make_item(CMD_STEP, 5'd0, 5'd0, 8'd1));
        send_command(make_item(CMD_STEP, 5'd0, 5'd0, 8'd255));

        // top start state, every state accepting
        wait_drained();
        write_register(CFG_START_STATE, 32'd31);
        write_register(CFG_ACCEPT_MASK, 32'hFFFF_FFFF);
        cfg_valid <= 1'b0;
        send_command(make_item(CMD_START, 5'd0, 5'd0, 8'd0));
        send_command(make_item(CMD_STEP, 5'd0, 5'd0, 8'd0));
        send_command(make_item(CMD_REMOVE_SYM, 5'd31, 5'd0, 8'd0));
        send_command(make_item(CMD_STEP, 5'd0, 5'd0, 8'd0));

        // random phases: most build a small graph over six states and three symbols, every seventh an epsilon chain
        while (sent < ITEM_TARGET) begin
            chain = (phases % 7 == 3);
            case ($urandom_range(0, 3))
                0:       st = 5'd0;
                1:       st = 5'd31;
                default: st = 5'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0:       mask = 32'h0000_0000;
                1:       mask = 32'hFFFF_FFFF;
                2:       mask = 32'd1 << $urandom_range(0, 31);
                default: mask = $urandom;
            endcase
            if (chain) begin
                st = 5'd0;
            end
            wait_drained();
            write_register(CFG_START_STATE, 32'(st));
            write_register(CFG_ACCEPT_MASK, mask);
            cfg_valid <= 1'b0;

            state_pool[0] = st;
            for (k = 1; k < 6; k++) begin
                state_pool[k] = 5'($urandom);
            end
            for (k = 0; k < 3; k++) begin
                symbol_pool[k] = 8'($urandom);
            end
            case ($urandom_range(0, 2))
                0:       symbol_pool[0] = 8'd0;
                1:       symbol_pool[0] = 8'd255;
                default: begin
                end
            endcase

            if (chain) begin
                // epsilon chain through every state: the longest closure
                for (k = 0; k < 31; k++) begin
                    item = make_item(CMD_ADD_EPS, k[4:0], k[4:0] + 5'd1, 8'($urandom));
                    send_command(item);
                    undo_eps.push_back(item);
                end
                send_command(make_item(CMD_ADD_SYM, 5'd31, 5'd0, symbol_pool[0]));
                send_command(make_item(CMD_START, 5'($urandom), 5'($urandom),
                                       8'($urandom)));
                for (k = 0; k < 4; k++) begin
                    send_command(make_item(CMD_STEP, 5'($urandom), 5'($urandom),
                                           pick_symbol()));
                end
                send_command(make_item(CMD_REMOVE_SYM, 5'd31, 5'd0, symbol_pool[0]));
            end else begin
                budget = $urandom_range(50, 90);
                for (k = 0; k < budget; k++) begin
                    if (k < 9) begin
                        r = (k % 4 == 3) ? 40 : 0;
                    end else if (k == 9) begin
                        r = 55;
                    end else begin
                        r = $urandom_range(0, 99);
                    end
                    if (r < 28) begin
                        item = make_item(CMD_ADD_SYM, pick_state(), pick_state(),
                                         pick_symbol());
                        added_sym.push_back(item);
                    end else if (r < 38) begin
                        if (added_sym.size() != 0 && $urandom_range(0, 1) == 0) begin
                            item = added_sym[$urandom_range(0, added_sym.size() - 1)];
                            item.command = CMD_REMOVE_SYM;
                        end else begin
                            item = make_item(CMD_REMOVE_SYM, pick_state(), pick_state(),
                                             pick_symbol());
                        end
                    end else if (r < 46) begin
                        item = make_item(CMD_ADD_EPS, pick_state(), pick_state(),
                                         8'($urandom));
                        undo_eps.push_back(item);
                    end else if (r < 51) begin
                        item = make_item(CMD_REMOVE_EPS, pick_state(), pick_state(),
                                         8'($urandom));
                    end else if (r < 61) begin
                        item = make_item(CMD_START, 5'($urandom), 5'($urandom),
                                         8'($urandom));
                    end else if (r < 93) begin
                        item = make_item(CMD_STEP, 5'($urandom), 5'($urandom),
                                         ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                                     : pick_symbol());
                    end else begin
                        // noise over the whole item, spare codes included
                        raw  = 21'($urandom);
                        item = raw;
                    end
                    send_command(item);
                end
            end

            // take the phase's epsilon edges out again so closures stay small
            while (undo_eps.size() != 0) begin
                item = undo_eps.pop_front();
                item.command = CMD_REMOVE_EPS;
                send_command(item);
            end
            added_sym.delete();
            phases++;
        end

        // closing: everything taken, then a short tail for stray results
        wait_drained();
        repeat (200) @(posedge aclk);

        $display("covered %0d items (%0d steps, %0d starts) over %0d random graph phases",
                 sent, step_count, start_count, phases);
        $display("with %0d register writes, edge add and remove hits and misses, spare codes",
                 reg_writes);
        if (failures == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/nfam_pkg.sv
sv/nfam_ram.sv
sv/nfa_state_set_matcher_core.sv
sv/nfam_checker.sv
sim/nfa_match_checker.sv
sim/tb_nfa_state_set_matcher_core.sv
